>>> design/serial_frame_receiver_core_defines.svh
// ---------------------------------------------------------------------------
// serial_frame_receiver_core_defines.svh
// Assertion macros used by the frame receiver checker.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Types, codes and sizes shared by the serial frame receiver.
// ---------------------------------------------------------------------------
package sfr_pkg;

   // Buffer size and derived widths
   localparam int BUFFER_LEN = 64;
   localparam int IDX_W      = $clog2(BUFFER_LEN);
   localparam int DEXP_W     = $clog2(BUFFER_LEN + 1);

   localparam logic [7:0] START_BYTE_RESET = 8'h7E;

   typedef logic [IDX_W-1:0]  sfr_idx_type;
   typedef logic [DEXP_W-1:0] sfr_dexp_type;

   // Request codes
   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_HEADER   = 3'd0;
   localparam logic [2:0] ST_DATA     = 3'd1;
   localparam logic [2:0] ST_OK       = 3'd2;
   localparam logic [2:0] ST_BAD      = 3'd3;
   localparam logic [2:0] ST_STRAY    = 3'd4;
   localparam logic [2:0] ST_IGNORED  = 3'd5;
   localparam logic [2:0] ST_READ     = 3'd6;
   localparam logic [2:0] ST_RELEASED = 3'd7;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
      logic [5:0] read_index;
   } sfr_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        frame_ready;
      logic [15:0] command;
      logic [5:0]  data_count;
      logic [7:0]  read_data;
   } sfr_rsp_type;

   // Buffer write port
   typedef struct packed {
      logic        we;
      sfr_idx_type addr;
      logic [7:0]  data;
   } sfr_wr_type;

endpackage

>>> design/sfr_ram.sv
// ---------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/sfr_frame.sv
// ---------------------------------------------------------------------------
// sfr_frame
// Frame parser state: header fields, checksum, buffer valid bits, hold flag.
// Computes the result of the item in the input register and commits the
// state update when that item advances.
// ---------------------------------------------------------------------------
module sfr_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [7:0]          csr_wdata,
   input  logic                fire,
   input  sfr_pkg::sfr_req_type item,
   input  logic [7:0]          rd_data,
   output sfr_pkg::sfr_rsp_type rsp,
   output sfr_pkg::sfr_wr_type  wr
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_CMD_HI,
      PH_CMD_LO,
      PH_BODY
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [7:0]                      start_ff;
   sfr_pkg::sfr_dexp_type           dexp_ff, dexp_in;
   logic                            hi_nz_ff, hi_nz_in;
   sfr_pkg::sfr_idx_type            wpos_ff, wpos_in;
   logic [15:0]                     cmd_ff, cmd_in;
   logic [7:0]                      sum_ff, sum_in;
   logic                            held_ff, held_in;
   logic [sfr_pkg::BUFFER_LEN-1:0]  written_ff, written_in;

   logic [7:0] b;
   logic [7:0] sum_add;
   logic [2:0] status;
   logic [7:0] rdata;

   assign b       = item.rx_byte;
   assign sum_add = sum_ff + b;

   // Next state and result for the item in the input register
   always_comb begin
      phase_in   = phase_ff;
      dexp_in    = dexp_ff;
      hi_nz_in   = hi_nz_ff;
      wpos_in    = wpos_ff;
      cmd_in     = cmd_ff;
      sum_in     = sum_ff;
      held_in    = held_ff;
      written_in = written_ff;
      status     = sfr_pkg::ST_IGNORED;
      rdata      = 8'h00;
      wr.we      = 1'b0;
      wr.addr    = wpos_ff;
      wr.data    = b;

      case (item.req_type)
         sfr_pkg::REQ_BYTE: begin
            if (held_ff) begin
               status = sfr_pkg::ST_IGNORED;
            end else if (b == start_ff) begin
               // restart the frame from any phase
               phase_in   = PH_LEN_HI;
               dexp_in    = '0;
               hi_nz_in   = 1'b0;
               wpos_in    = '0;
               cmd_in     = 16'h0000;
               sum_in     = 8'h00;
               written_in = '0;
               status     = sfr_pkg::ST_HEADER;
            end else begin
               unique case (phase_ff)
                  PH_LEN_HI: begin
                     hi_nz_in = (b != 8'h00);
                     sum_in   = sum_add;
                     phase_in = PH_LEN_LO;
                     status   = sfr_pkg::ST_HEADER;
                  end
                  PH_LEN_LO: begin
                     // cap the length at the buffer size
                     if (hi_nz_ff || (b >= 8'(sfr_pkg::BUFFER_LEN))) begin
                        dexp_in = sfr_pkg::sfr_dexp_type'(sfr_pkg::BUFFER_LEN);
                     end else begin
                        dexp_in = sfr_pkg::sfr_dexp_type'(b);
                     end
                     sum_in   = sum_add;
                     phase_in = PH_CMD_HI;
                     status   = sfr_pkg::ST_HEADER;
                  end
                  PH_CMD_HI: begin
                     cmd_in = {b, 8'h00};
                     sum_in = sum_add;
                     if (dexp_ff != '0) begin
                        dexp_in = dexp_ff - 1'b1;
                     end
                     phase_in = PH_CMD_LO;
                     status   = sfr_pkg::ST_HEADER;
                  end
                  PH_CMD_LO: begin
                     cmd_in = {cmd_ff[15:8], b};
                     sum_in = sum_add;
                     if (dexp_ff != '0) begin
                        dexp_in = dexp_ff - 1'b1;
                     end
                     wpos_in  = '0;
                     phase_in = PH_BODY;
                     status   = sfr_pkg::ST_HEADER;
                  end
                  PH_BODY: begin
                     if ({1'b0, wpos_ff} < dexp_ff) begin
                        // store a data byte
                        wr.we               = fire;
                        written_in[wpos_ff] = 1'b1;
                        sum_in              = sum_add;
                        wpos_in             = wpos_ff + 1'b1;
                        status              = sfr_pkg::ST_DATA;
                     end else if (~sum_ff == b) begin
                        held_in = 1'b1;
                        status  = sfr_pkg::ST_OK;
                     end else begin
                        // drop the frame on a checksum mismatch
                        phase_in   = PH_IDLE;
                        dexp_in    = '0;
                        hi_nz_in   = 1'b0;
                        wpos_in    = '0;
                        cmd_in     = 16'h0000;
                        sum_in     = 8'h00;
                        written_in = '0;
                        status     = sfr_pkg::ST_BAD;
                     end
                  end
                  default: begin
                     // stray byte outside a frame
                     phase_in   = PH_IDLE;
                     dexp_in    = '0;
                     hi_nz_in   = 1'b0;
                     wpos_in    = '0;
                     cmd_in     = 16'h0000;
                     sum_in     = 8'h00;
                     written_in = '0;
                     status     = sfr_pkg::ST_STRAY;
                  end
               endcase
            end
         end
         sfr_pkg::REQ_RELEASE: begin
            if (held_ff) begin
               phase_in   = PH_IDLE;
               dexp_in    = '0;
               hi_nz_in   = 1'b0;
               wpos_in    = '0;
               cmd_in     = 16'h0000;
               sum_in     = 8'h00;
               held_in    = 1'b0;
               written_in = '0;
               status     = sfr_pkg::ST_RELEASED;
            end
         end
         sfr_pkg::REQ_READ: begin
            status = sfr_pkg::ST_READ;
            if (written_ff[item.read_index]) begin
               rdata = rd_data;
            end
         end
         default: begin
            status = sfr_pkg::ST_IGNORED;
         end
      endcase
   end

   // Result fields show the state after the item
   always_comb begin
      rsp.status      = status;
      rsp.frame_ready = held_in;
      rsp.command     = cmd_in;
      rsp.data_count  = dexp_in[sfr_pkg::IDX_W-1:0];
      rsp.read_data   = rdata;
   end

   // Hold state, advance on fire
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= sfr_pkg::START_BYTE_RESET;
         phase_ff   <= PH_IDLE;
         dexp_ff    <= '0;
         hi_nz_ff   <= 1'b0;
         wpos_ff    <= '0;
         cmd_ff     <= 16'h0000;
         sum_ff     <= 8'h00;
         held_ff    <= 1'b0;
         written_ff <= '0;
      end else begin
         if (csr_we) begin
            start_ff <= csr_wdata;
         end
         if (fire) begin
            phase_ff   <= phase_in;
            dexp_ff    <= dexp_in;
            hi_nz_ff   <= hi_nz_in;
            wpos_ff    <= wpos_in;
            cmd_ff     <= cmd_in;
            sum_ff     <= sum_in;
            held_ff    <= held_in;
            written_ff <= written_in;
         end
      end
   end

endmodule

>>> design/serial_frame_receiver_core.sv
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while the result side is not stalled;
// the buffer RAM is read at accept time and written when the item leaves
// the input register.
// Reset: synchronous; clears control state and the buffer valid bits,
// start byte returns to 0x7E; buffer RAM contents are left as they are.
// ---------------------------------------------------------------------------
// serial_frame_receiver_core
// Length-prefixed serial frame receiver with checksum, frame hold and
// indexed buffer read-back.
// ---------------------------------------------------------------------------
module serial_frame_receiver_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sfr_pkg::sfr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sfr_pkg::sfr_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [7:0]           csr_wdata
);

   logic                  s1_valid_ff;
   sfr_pkg::sfr_req_type  s1_item_ff;
   logic                  rsp_valid_ff;
   sfr_pkg::sfr_rsp_type  rsp_data_ff;
   logic                  byp_valid_ff;
   sfr_pkg::sfr_idx_type  byp_addr_ff;
   logic [7:0]            byp_data_ff;

   logic                  s1_fire;
   logic                  req_fire;
   logic [7:0]            ram_rdata;
   logic [7:0]            rd_fwd;
   sfr_pkg::sfr_rsp_type  rsp_next;
   sfr_pkg::sfr_wr_type   wr;

   // Handshake
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Buffer storage, read as the item is accepted
   sfr_ram #(
      .WIDTH(8),
      .DEPTH(sfr_pkg::BUFFER_LEN)
   ) u_sfr_ram (
      .clock(clock),
      .we   (wr.we),
      .waddr(wr.addr),
      .wdata(wr.data),
      .re   (req_fire),
      .raddr(req_data.read_index),
      .rdata(ram_rdata)
   );

   // Forward a write that lands on the same edge as the read
   assign rd_fwd = (byp_valid_ff && (byp_addr_ff == s1_item_ff.read_index)) ?
                   byp_data_ff : ram_rdata;

   sfr_frame u_sfr_frame (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .fire     (s1_fire),
      .item     (s1_item_ff),
      .rd_data  (rd_fwd),
      .rsp      (rsp_next),
      .wr       (wr)
   );

   // Input register, result register and write bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
            byp_valid_ff <= wr.we;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         s1_item_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_next;
         byp_addr_ff <= wr.addr;
         byp_data_ff <= wr.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/sfr_checker.sv
// ---------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the frame receiver results.
// ---------------------------------------------------------------------------
`include "serial_frame_receiver_core_defines.svh"

module sfr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sfr_pkg::sfr_rsp_type rsp_data
);

   logic rsp_ok;
   logic rsp_cleared;
   logic rsp_data_st;
   logic rsp_other;

   assign rsp_ok      = rsp_valid && (rsp_data.status == sfr_pkg::ST_OK);
   assign rsp_cleared = rsp_valid && ((rsp_data.status == sfr_pkg::ST_BAD) ||
                        (rsp_data.status == sfr_pkg::ST_STRAY) ||
                        (rsp_data.status == sfr_pkg::ST_RELEASED));
   assign rsp_data_st = rsp_valid && ((rsp_data.status == sfr_pkg::ST_DATA) ||
                        (rsp_data.status == sfr_pkg::ST_HEADER));
   assign rsp_other   = rsp_valid && (rsp_data.status != sfr_pkg::ST_READ);

   // A checked frame is reported as held
   `SFR_ASSERT_NOW(a_ok_held, clock, reset, rsp_ok, rsp_data.frame_ready,
      "frame ok without frame_ready")

   // Dropped or released frames leave nothing behind
   `SFR_ASSERT_NOW(a_clear_empty, clock, reset, rsp_cleared,
      (!rsp_data.frame_ready && (rsp_data.command == 16'h0000) &&
       (rsp_data.data_count == 6'd0)),
      "frame state not cleared")

   // Header and data bytes are only taken while no frame is held
   `SFR_ASSERT_NOW(a_take_not_held, clock, reset, rsp_data_st, !rsp_data.frame_ready,
      "byte taken while a frame is held")

   // Only reads carry buffer data
   `SFR_ASSERT_NOW(a_read_data_zero, clock, reset, rsp_other,
      (rsp_data.read_data == 8'h00),
      "read_data nonzero outside a read")

   // A stalled result holds
   `SFR_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready),
      (rsp_valid && $stable(rsp_data)),
      "stalled result changed")

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for serial_frame_receiver_core. Frames, stray bytes,
// releases and buffer reads go in over the request channel, and a frame
// model predicts each response for in-order comparison. Both sides idle at
// random. The response side also stalls for a long stretch. The start byte
// register is swept through its extremes.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] REQ_UNUSED     = 2'd3;

   // Ways a generated frame may end
   localparam int FRAME_GOOD    = 0;
   localparam int FRAME_BAD_SUM = 1;
   localparam int FRAME_CUT     = 2;

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_CMD_HI, PH_CMD_LO, PH_BODY
   } rx_phase_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   sfr_pkg::sfr_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   sfr_pkg::sfr_rsp_type rsp_data;
   logic                 csr_we;
   logic [7:0]           csr_wdata;

   // Frame model state
   logic [7:0]      start_byte_m;
   rx_phase_type    phase_m;
   int unsigned     dexp_m;
   int unsigned     wpos_m;
   logic [15:0]     cmd_m;
   logic [7:0]      sum_m;
   logic            held_m;
   logic [7:0]      store_m [sfr_pkg::BUFFER_LEN];
   logic [63:0]     written_m;

   sfr_pkg::sfr_rsp_type frame_rsp_q[$];
   int                   mismatch_count;
   int                   counted_items;
   bit                   idle_on;
   int                   hold_off_req;

   serial_frame_receiver_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Frame model
   // ------------------------------------------------------------------
   function automatic void clear_frame_m();
      foreach (store_m[i]) store_m[i] = 8'h00;
      written_m = '0;
      phase_m   = PH_IDLE;
      dexp_m    = 0;
      wpos_m    = 0;
      cmd_m     = '0;
      sum_m     = '0;
      held_m    = 1'b0;
   endfunction

   function automatic logic [2:0] take_byte_m(input logic [7:0] b);
      if (held_m) return sfr_pkg::ST_IGNORED;
      // a start byte restarts the frame from any phase
      if (b == start_byte_m) begin
         clear_frame_m();
         phase_m = PH_LEN_HI;
         return sfr_pkg::ST_HEADER;
      end
      case (phase_m)
         PH_LEN_HI: begin
            dexp_m  = 32'(b) << 8;
            sum_m   = sum_m + b;
            phase_m = PH_LEN_LO;
            return sfr_pkg::ST_HEADER;
         end
         PH_LEN_LO: begin
            dexp_m = dexp_m | 32'(b);
            if (dexp_m >= sfr_pkg::BUFFER_LEN) dexp_m = sfr_pkg::BUFFER_LEN;
            sum_m   = sum_m + b;
            phase_m = PH_CMD_HI;
            return sfr_pkg::ST_HEADER;
         end
         PH_CMD_HI: begin
            cmd_m[15:8] = b;
            cmd_m[7:0]  = 8'h00;
            sum_m       = sum_m + b;
            if (dexp_m > 0) dexp_m--;
            phase_m = PH_CMD_LO;
            return sfr_pkg::ST_HEADER;
         end
         PH_CMD_LO: begin
            cmd_m[7:0] = b;
            sum_m      = sum_m + b;
            if (dexp_m > 0) dexp_m--;
            wpos_m  = 0;
            phase_m = PH_BODY;
            return sfr_pkg::ST_HEADER;
         end
         PH_BODY: begin
            if (wpos_m < dexp_m) begin
               store_m[wpos_m]   = b;
               written_m[wpos_m] = 1'b1;
               sum_m             = sum_m + b;
               wpos_m++;
               return sfr_pkg::ST_DATA;
            end
            if (8'(~sum_m) == b) begin
               held_m = 1'b1;
               return sfr_pkg::ST_OK;
            end
            clear_frame_m();
            return sfr_pkg::ST_BAD;
         end
         default: begin
            clear_frame_m();
            return sfr_pkg::ST_STRAY;
         end
      endcase
   endfunction

   function automatic sfr_pkg::sfr_rsp_type frame_step(input sfr_pkg::sfr_req_type it);
      sfr_pkg::sfr_rsp_type r;
      logic [2:0]           st;
      logic [7:0]           rd;
      st = sfr_pkg::ST_IGNORED;
      rd = 8'h00;
      case (it.req_type)
         sfr_pkg::REQ_BYTE: st = take_byte_m(it.rx_byte);
         sfr_pkg::REQ_RELEASE: begin
            if (held_m) begin
               clear_frame_m();
               st = sfr_pkg::ST_RELEASED;
            end
         end
         sfr_pkg::REQ_READ: begin
            st = sfr_pkg::ST_READ;
            if (written_m[it.read_index]) rd = store_m[it.read_index];
         end
         default: ;
      endcase
      r.status      = st;
      r.frame_ready = held_m;
      r.command     = cmd_m;
      r.data_count  = dexp_m[5:0];
      r.read_data   = rd;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Predict on each accepted item, compare each accepted result
   // ------------------------------------------------------------------
   task automatic note_mismatch(input string why, input sfr_pkg::sfr_rsp_type exp,
                                input sfr_pkg::sfr_rsp_type act);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected st %0d rdy %0d cmd %h cnt %0d rd %h",
                  $realtime, why, exp.status, exp.frame_ready, exp.command,
                  exp.data_count, exp.read_data);
         $display("   got st %0d rdy %0d cmd %h cnt %0d rd %h",
                  act.status, act.frame_ready, act.command, act.data_count,
                  act.read_data);
      end
   endtask

   always @(posedge clock) begin : frame_check
      sfr_pkg::sfr_rsp_type pred;
      sfr_pkg::sfr_rsp_type exp;
      if (!reset && req_valid && req_ready) begin
         pred = frame_step(req_data);
         frame_rsp_q.push_back(pred);
         if (pred.status != sfr_pkg::ST_IGNORED) counted_items++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_rsp_q.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_data);
         end else begin
            exp = frame_rsp_q.pop_front();
            if (rsp_data.status !== exp.status ||
                rsp_data.frame_ready !== exp.frame_ready ||
                rsp_data.command !== exp.command ||
                rsp_data.data_count !== exp.data_count ||
                rsp_data.read_data !== exp.read_data)
               note_mismatch("result differs", exp, rsp_data);
         end
      end
   end

   // ------------------------------------------------------------------
   // Response side: random stalls, plus a long hold when requested
   // ------------------------------------------------------------------
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin : rsp_side
      int stall_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_off_req > 0) begin
            rsp_ready    <= 1'b0;
            stall_left   = hold_off_req - 1;
            hold_off_req = 0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_left = idle_gap();
         end
      end
   end

   // Abort when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("serial_frame_receiver_core: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic send_item(input sfr_pkg::sfr_req_type it);
      int gap;
      gap = idle_on ? idle_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold until every pending result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (frame_rsp_q.size() != 0);
   endtask

   task automatic write_start(input logic [7:0] v);
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we       <= 1'b0;
      start_byte_m = v;
   endtask

   function automatic sfr_pkg::sfr_req_type rx_item(input logic [7:0] b);
      sfr_pkg::sfr_req_type it;
      it.req_type   = sfr_pkg::REQ_BYTE;
      it.rx_byte    = b;
      it.read_index = 6'($urandom);
      return it;
   endfunction

   function automatic sfr_pkg::sfr_req_type read_item(input logic [5:0] idx);
      sfr_pkg::sfr_req_type it;
      it.req_type   = sfr_pkg::REQ_READ;
      it.rx_byte    = 8'($urandom);
      it.read_index = idx;
      return it;
   endfunction

   function automatic sfr_pkg::sfr_req_type ctl_item(input logic [1:0] kind);
      sfr_pkg::sfr_req_type it;
      it.req_type   = kind;
      it.rx_byte    = 8'($urandom);
      it.read_index = 6'($urandom);
      return it;
   endfunction

   // Random byte that does not restart the frame
   function automatic logic [7:0] frame_byte();
      logic [7:0] v;
      do v = 8'($urandom); while (v == start_byte_m);
      return v;
   endfunction

   // Mostly short lengths; redraw when a length byte would look like a start
   function automatic logic [15:0] pick_len();
      logic [15:0] len;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 16'($urandom_range(0, 1));
      else if (r < 80) len = 16'($urandom_range(2, 20));
      else if (r < 92) len = 16'($urandom_range(21, 70));
      else             len = 16'($urandom);
      while (len[15:8] == start_byte_m || len[7:0] == start_byte_m) len = 16'($urandom);
      return len;
   endfunction

   task automatic send_frame(input logic [15:0] len, input logic [15:0] cmd, input int mode);
      int unsigned capped;
      int          n_data;
      logic [7:0]  sum;
      logic [7:0]  b;
      capped = (len >= sfr_pkg::BUFFER_LEN) ? sfr_pkg::BUFFER_LEN : len;
      n_data = (capped > 2) ? capped - 2 : 0;
      if (mode == FRAME_CUT) n_data = $urandom_range(0, (n_data < 2) ? n_data : 2);
      sum = len[15:8] + len[7:0] + cmd[15:8] + cmd[7:0];
      send_item(rx_item(start_byte_m));
      send_item(rx_item(len[15:8]));
      send_item(rx_item(len[7:0]));
      send_item(rx_item(cmd[15:8]));
      send_item(rx_item(cmd[7:0]));
      for (int i = 0; i < n_data; i++) begin
         b   = frame_byte();
         sum = sum + b;
         send_item(rx_item(b));
      end
      // a cut frame stops here and is restarted by the next start byte
      if (mode == FRAME_GOOD)
         send_item(rx_item(~sum));
      else if (mode == FRAME_BAD_SUM)
         send_item(rx_item(~sum ^ 8'($urandom_range(1, 255))));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // stray byte, release with nothing held, unused request
      send_item(rx_item(8'h00));
      send_item(ctl_item(sfr_pkg::REQ_RELEASE));
      send_item(ctl_item(REQ_UNUSED));
      // good frame with two data bytes, extreme command word
      send_frame(16'h0004, 16'hFFFF, FRAME_GOOD);
      // read written and unwritten entries while held
      send_item(read_item(6'd0));
      send_item(read_item(6'd63));
      // start byte is ignored while a frame is held
      send_item(rx_item(start_byte_m));
      send_item(ctl_item(sfr_pkg::REQ_RELEASE));
      // length beyond the buffer, broken off by a new start byte
      send_frame(16'hFFFF, 16'h0000, FRAME_CUT);
      // length under two with a bad checksum
      send_frame(16'h0001, {frame_byte(), frame_byte()}, FRAME_BAD_SUM);
   endtask

   task automatic test_random_traffic(input int target);
      int base;
      int r;
      int mode;
      base = counted_items;
      while (counted_items - base < target) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            r    = $urandom_range(0, 99);
            mode = (r < 75) ? FRAME_GOOD : (r < 90) ? FRAME_BAD_SUM : FRAME_CUT;
            send_frame(pick_len(), {frame_byte(), frame_byte()}, mode);
            if (mode == FRAME_GOOD) begin
               // poke the held frame, then usually let it go
               repeat ($urandom_range(0, 3)) begin
                  if ($urandom_range(0, 3) == 0) send_item(rx_item(8'($urandom)));
                  else send_item(read_item(6'($urandom_range(0, 15))));
               end
               if ($urandom_range(0, 9) != 0) send_item(ctl_item(sfr_pkg::REQ_RELEASE));
            end
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: send_item(rx_item(8'($urandom)));
               3, 4, 5: send_item(read_item(6'($urandom)));
               6, 7:    send_item(ctl_item(sfr_pkg::REQ_RELEASE));
               8:       send_item(ctl_item(REQ_UNUSED));
               default: send_item(rx_item(start_byte_m));
            endcase
         end
      end
   endtask

   // Hold off responses while items keep coming, then drain and send more
   task automatic test_backpressure();
      idle_on      = 1'b0;
      hold_off_req = 80;
      test_random_traffic(25);
      wait_drain();
      test_random_traffic(15);
      idle_on = 1'b1;
   endtask

   task automatic test_start_byte(input logic [7:0] v);
      write_start(v);
      test_random_traffic(40);
   endtask

   initial begin : run
      logic [7:0] mid;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      idle_on        = 1'b1;
      hold_off_req   = 0;
      mismatch_count = 0;
      counted_items  = 0;
      start_byte_m   = sfr_pkg::START_BYTE_RESET;
      clear_frame_m();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(330);
      test_backpressure();
      test_start_byte(8'h00);
      test_start_byte(8'hFF);
      do mid = 8'($urandom);
      while (mid == 8'h00 || mid == 8'hFF || mid == sfr_pkg::START_BYTE_RESET);
      test_start_byte(mid);
      test_start_byte(sfr_pkg::START_BYTE_RESET);

      wait_drain();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0)
         $display("serial_frame_receiver_core: match");
      else
         $display("serial_frame_receiver_core: mismatch");
      $finish;
   end

endmodule
